[hdl/stw_pkg.sv]
// span timer package: request and mode codes, control/status structs,
// shared saturation helpers; no dependencies
package stw_pkg;

  // widths
  localparam int TIME_W  = 44;   // working time during a tick
  localparam int COUNT_W = 8;    // spans per item
  localparam int SHOW_W  = 50;   // displayed-time sum before saturation

  // request codes
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;

  // mode codes
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_REVERSE  = 3'd1;
  localparam logic [2:0] MODE_CONT     = 3'd2;
  localparam logic [2:0] MODE_CONT_REV = 3'd3;
  localparam logic [2:0] MODE_LOOP     = 3'd4;
  localparam logic [2:0] MODE_LOOP_REV = 3'd5;
  localparam logic [2:0] MODE_PINGPONG = 3'd6;
  localparam logic [2:0] MODE_UNUSED   = 3'd7;

  localparam logic signed [15:0] CYC_MAX = 16'sh7fff;
  localparam logic signed [15:0] CYC_MIN = -16'sh8000;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] span_start;
    logic signed [31:0] span_end;
    logic signed [15:0] rate;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture the input transaction
    logic exec;       // start, toggle or first tick step
    logic add;        // add the scaled step to the time
    logic wrap_step;  // one wrap, clamp or reflection
    logic wrap_end;   // close the wrap loop, record overflow
    logic sat;        // write back the saturated time
    logic show;       // length times cycle product
    logic out_load;   // fill the output register
  } cmd_t;

  typedef struct packed {
    logic tick_go;    // tick that moves the time
    logic wrap_cont;  // another wrap iteration is due
    logic out_free;   // output register can take a result
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [TIME_W-1:0] v);
    logic signed [31:0] r;
    if (v[TIME_W-1:31] == '0 || v[TIME_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[TIME_W-1]) begin
      r = {1'b1, 31'b0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [SHOW_W-1:0] v);
    logic signed [47:0] r;
    if (v[SHOW_W-1:47] == '0 || v[SHOW_W-1:47] == '1) begin
      r = v[47:0];
    end else if (v[SHOW_W-1]) begin
      r = {1'b1, 47'b0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

endpackage

[hdl/stw_apb_regs.sv]
// span timer configuration registers behind an apb-style port
// depends on stw_pkg
module stw_apb_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output stw_pkg::cfg_t       cfg
);

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;
  localparam logic [1:0] REG_RATE  = 2'd3;

  logic [1:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= stw_pkg::MODE_NORMAL;
      cfg.span_start <= 32'sh0;
      cfg.span_end   <= 32'sh0001_0000;
      cfg.rate       <= 16'sh0100;
    end else if (wr) begin
      case (idx)
        REG_MODE:  cfg.mode       <= pwdata[2:0];
        REG_START: cfg.span_start <= pwdata;
        REG_END:   cfg.span_end   <= pwdata;
        REG_RATE:  cfg.rate       <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:  prdata = {29'b0, cfg.mode};
      REG_START: prdata = cfg.span_start;
      REG_END:   prdata = cfg.span_end;
      REG_RATE:  prdata = {16'b0, cfg.rate};
      default:   prdata = '0;
    endcase
  end

endmodule

[hdl/stw_ctrl.sv]
// span timer sequencer: steps one transaction through exec, then add,
// wrap and saturate on a moving tick, display and output; uses stw_pkg
module stw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  stw_pkg::sts_t sts,
  output stw_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_WRAP = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_SHOW = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.tick_go ? S_ADD : S_SHOW;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_WRAP;
      end
      S_WRAP: begin
        if (sts.wrap_cont) begin
          cmd.wrap_step = 1'b1;
        end else begin
          cmd.wrap_end = 1'b1;
          state_next   = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        cmd.show   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/stw_datapath.sv]
// span timer datapath: timer state, step multiplier, wrap unit, display
// product and output register; depends on stw_pkg
module stw_datapath #(
  parameter int MAX_WRAPS = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  stw_pkg::cmd_t       cmd,
  output stw_pkg::sts_t       sts,
  input  stw_pkg::cfg_t       cfg,
  input  logic [1:0]          req_type,
  input  logic [23:0]         step_amount,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [47:0]  time_now,
  output logic signed [15:0]  cycle_count,
  output logic [31:0]         spans_total,
  output logic [7:0]          spans_this_step,
  output logic                is_running,
  output logic                going_down,
  output logic                wrap_overflow
);

  localparam int TW = stw_pkg::TIME_W;
  localparam int CW = stw_pkg::COUNT_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_WRAPS);

  // transaction
  logic [1:0]  req;
  logic [23:0] step;

  // timer state
  logic signed [31:0] time_acc;
  logic signed [15:0] cycle_reg;
  logic [31:0]        span_counter;
  logic               dir_negative;
  logic [2:0]         active_mode;
  logic               running_flag;

  // working registers
  logic signed [40:0]          prod;
  logic signed [TW-1:0]        t;
  logic [CW-1:0]               count;
  logic                        ovf;
  logic                        stopped;
  logic signed [48:0]          disp_prod;

  // combinational
  logic signed [32:0]          len33;
  logic signed [TW-1:0]        st_x, en_x, len_x, t_refl;
  logic signed [24:0]          step_s;
  logic signed [40:0]          prod_full;
  logic signed [48:0]          disp_full;
  logic signed [stw_pkg::SHOW_W-1:0] show_sum;
  logic [2:0]                  start_mode;
  logic                        start_dir;
  logic                        cond, cap_ok, clamp_mode;
  logic [31:0]                 span_inc;

  assign len33 = 33'(cfg.span_end) - 33'(cfg.span_start);
  assign st_x  = TW'(cfg.span_start);
  assign en_x  = TW'(cfg.span_end);
  assign len_x = TW'(len33);

  assign step_s    = {1'b0, step};
  assign prod_full = 41'(step_s) * 41'(cfg.rate);
  assign disp_full = 49'(len33) * 49'(cycle_reg);
  assign show_sum  = stw_pkg::SHOW_W'(time_acc) + stw_pkg::SHOW_W'(disp_prod);

  assign start_mode = (cfg.mode == stw_pkg::MODE_UNUSED) ? stw_pkg::MODE_NORMAL : cfg.mode;
  assign start_dir  = (start_mode == stw_pkg::MODE_REVERSE) ||
                      (start_mode == stw_pkg::MODE_CONT_REV) ||
                      (start_mode == stw_pkg::MODE_LOOP_REV);

  assign t_refl   = (t < st_x) ? (st_x <<< 1) - t : (en_x <<< 1) - t;
  assign span_inc = (span_counter == '1) ? span_counter : span_counter + 32'd1;

  // loop condition per mode
  always_comb begin
    clamp_mode = 1'b0;
    cap_ok     = (count < CAP);
    case (active_mode)
      stw_pkg::MODE_NORMAL: begin
        cond       = (t >= en_x);
        clamp_mode = 1'b1;
        cap_ok     = (count == '0);
      end
      stw_pkg::MODE_REVERSE: begin
        cond       = (t < st_x);
        clamp_mode = 1'b1;
        cap_ok     = (count == '0);
      end
      stw_pkg::MODE_CONT, stw_pkg::MODE_LOOP:         cond = (t >= en_x);
      stw_pkg::MODE_CONT_REV, stw_pkg::MODE_LOOP_REV: cond = (t <= st_x);
      default: cond = ((t < st_x) || (t >= en_x)) && !stopped;
    endcase
  end

  assign sts.tick_go   = (req == stw_pkg::REQ_TICK) && running_flag &&
                         (step != '0) && (len33 != '0);
  assign sts.wrap_cont = cond && cap_ok;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_acc     <= '0;
      cycle_reg    <= '0;
      span_counter <= '0;
      dir_negative <= 1'b0;
      active_mode  <= stw_pkg::MODE_NORMAL;
      running_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (req)
          stw_pkg::REQ_START: begin
            active_mode  <= start_mode;
            dir_negative <= start_dir;
            time_acc     <= start_dir ? cfg.span_end : cfg.span_start;
            cycle_reg    <= '0;
            span_counter <= '0;
            running_flag <= 1'b1;
          end
          stw_pkg::REQ_TOGGLE: begin
            if (active_mode == stw_pkg::MODE_PINGPONG) begin
              dir_negative <= !dir_negative;
            end else begin
              active_mode[0] <= !active_mode[0];
              dir_negative   <= !active_mode[0];
            end
          end
          stw_pkg::REQ_TICK: begin
            // zero-length span stops the timer
            if (running_flag && step != '0 && len33 == '0) begin
              running_flag <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (cmd.wrap_step) begin
        span_counter <= span_inc;
        case (active_mode)
          stw_pkg::MODE_NORMAL: begin
            cycle_reg    <= 16'sd1;
            running_flag <= 1'b0;
          end
          stw_pkg::MODE_REVERSE: begin
            cycle_reg    <= -16'sd1;
            running_flag <= 1'b0;
          end
          stw_pkg::MODE_CONT: begin
            if (cycle_reg != stw_pkg::CYC_MAX) begin
              cycle_reg <= cycle_reg + 16'sd1;
            end
          end
          stw_pkg::MODE_CONT_REV: begin
            if (cycle_reg != stw_pkg::CYC_MIN) begin
              cycle_reg <= cycle_reg - 16'sd1;
            end
          end
          stw_pkg::MODE_LOOP, stw_pkg::MODE_LOOP_REV: ;
          default: dir_negative <= !dir_negative;
        endcase
      end

      if (cmd.sat) begin
        time_acc <= stw_pkg::sat32(t);
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= req_type;
      step <= step_amount;
    end
    if (cmd.exec) begin
      count   <= '0;
      ovf     <= 1'b0;
      stopped <= 1'b0;
      prod    <= dir_negative ? -prod_full : prod_full;
    end
    if (cmd.add) begin
      // arithmetic shift is floor division by 256
      t <= TW'(time_acc) + TW'(prod >>> 8);
    end
    if (cmd.wrap_step) begin
      count <= count + CW'(1);
      case (active_mode)
        stw_pkg::MODE_NORMAL:   t <= en_x;
        stw_pkg::MODE_REVERSE:  t <= st_x;
        stw_pkg::MODE_CONT, stw_pkg::MODE_LOOP:         t <= t - len_x;
        stw_pkg::MODE_CONT_REV, stw_pkg::MODE_LOOP_REV: t <= t + len_x;
        default: begin
          t       <= t_refl;
          stopped <= (t_refl == en_x);
        end
      endcase
    end
    if (cmd.wrap_end) begin
      ovf <= cond && !clamp_mode;
    end
    if (cmd.show) begin
      disp_prod <= disp_full;
    end
    if (cmd.out_load) begin
      if (active_mode == stw_pkg::MODE_CONT || active_mode == stw_pkg::MODE_CONT_REV) begin
        time_now <= stw_pkg::sat48(show_sum);
      end else begin
        time_now <= 48'(time_acc);
      end
      cycle_count     <= cycle_reg;
      spans_total     <= span_counter;
      spans_this_step <= count;
      is_running      <= running_flag;
      going_down      <= dir_negative;
      wrap_overflow   <= ovf;
    end
  end

endmodule

[hdl/span_timer_with_loop_modes.sv]
// span timer with loop modes, top level: apb registers, sequencer, datapath
// depends on stw_pkg, stw_apb_regs, stw_ctrl, stw_datapath
//
// One transaction in gives one transaction out. A start, a toggle, or a tick
// that leaves the time alone passes the exec, display and output states. A
// moving tick also passes the add state, the wrap state per wrap, clamp or
// reflection (up to MAX_WRAPS) and the saturate state. The wrap unit handles
// one span crossing per cycle. The output state waits for a free output
// register. Items are handled one at a time: in_ready is high only while
// the sequencer is idle, and a finished result sits in the output register
// while the next transaction is accepted and worked on. The time is signed
// Q16.16; a moving tick adds floor(p / 256), p = step_amount * rate, with p
// negated when counting down. Configuration registers sit at byte addresses
// 0 (mode), 4 (span_start), 8 (span_end) and 12 (rate); mode is taken in
// only by a start request. No clearing pass is needed after reset.
module span_timer_with_loop_modes #(
  parameter int MAX_WRAPS = 255
) (
  input  logic               clk,
  input  logic               rst,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [23:0]        step_amount,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] time_now,
  output logic signed [15:0] cycle_count,
  output logic [31:0]        spans_total,
  output logic [7:0]         spans_this_step,
  output logic               is_running,
  output logic               going_down,
  output logic               wrap_overflow
);

  stw_pkg::cfg_t cfg;
  stw_pkg::cmd_t cmd;
  stw_pkg::sts_t sts;

  // configuration registers
  stw_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: one state per phase of a transaction, waits in the wrap
  // state while the datapath reports another crossing
  stw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // timer state, step multiply, wrap unit and output register
  stw_datapath #(
    .MAX_WRAPS (MAX_WRAPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg),
    .req_type        (req_type),
    .step_amount     (step_amount),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .time_now        (time_now),
    .cycle_count     (cycle_count),
    .spans_total     (spans_total),
    .spans_this_step (spans_this_step),
    .is_running      (is_running),
    .going_down      (going_down),
    .wrap_overflow   (wrap_overflow)
  );

  // an accepted transaction keeps the sequencer busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted transaction");

  // the wrap unit never runs past its per-tick cap
  a_wrap_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (spans_this_step <= 8'(MAX_WRAPS)))
    else $error("spans_this_step above the wrap cap");

  // overflow is only flagged when the cap was actually used up
  a_ovf_at_cap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wrap_overflow) |-> (spans_this_step == 8'(MAX_WRAPS)))
    else $error("wrap_overflow without reaching the wrap cap");

endmodule
